### rtl/core/bmh_pkg.sv
// ============================================================================
// bmh_pkg
// Shared constants and codes for the binary min-heap priority queue.
// ============================================================================
package bmh_pkg;

    // Default configuration
    localparam int unsigned DEF_HEAP_DEPTH   = 1024;
    localparam int unsigned DEF_KEY_BITS     = 32;
    localparam int unsigned DEF_PAYLOAD_BITS = 16;

    // Fixed port widths
    localparam int unsigned KEY_PORT_W     = 32;
    localparam int unsigned PAYLOAD_PORT_W = 16;
    localparam int unsigned COUNT_PORT_W   = 11;

    // Item actions
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

endpackage

### rtl/core/binary_min_heap_priority_queue_top.sv
// ============================================================================
// binary_min_heap_priority_queue_top
// Binary min-heap of key/payload entries held in one on-chip memory.
// ============================================================================
// Start an item by raising start while busy is low; the item transfers on
// that clock edge. Each item produces exactly one result, shown on status,
// min_key, min_payload and count for a single cycle while done is high; the
// receiver cannot stall it, so capture it on that cycle. An insert that finds
// the heap full and a remove that finds it empty never raise busy; their
// result follows in the next cycle. An insert holds busy while the new entry
// climbs, one parent read (S_UP_RD) and one compare-and-write (S_UP_CMP) per
// level, until it is placed below a parent that is not larger or at the root.
// A remove holds busy while it reads the root and last entry (S_RM_RD), loads
// them (S_RM_LOAD), and then, unless that empties the heap, while the moved
// entry sinks, one child read (S_DN_RD) and one compare-and-write (S_DN_CMP)
// per level. Each level costs one registered memory read and one
// compare-and-write. done rises in the same cycle that busy falls, and the
// next item may transfer in that same cycle. The moving entry is held in a
// register and children or parents are written into its hole, so only one
// write per cycle reaches the memory. Keys compare unsigned; on the way down
// the left child wins ties and a child moves up only when strictly smaller.
// Memory contents are undefined after reset; only entries below the count
// are ever read for a result, so no clearing pass is needed.
// ============================================================================
module binary_min_heap_priority_queue_top #(
    parameter int unsigned HEAP_DEPTH   = bmh_pkg::DEF_HEAP_DEPTH,
    parameter int unsigned KEY_BITS     = bmh_pkg::DEF_KEY_BITS,
    parameter int unsigned PAYLOAD_BITS = bmh_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  action,
    input  logic [bmh_pkg::KEY_PORT_W-1:0]        key,
    input  logic [bmh_pkg::PAYLOAD_PORT_W-1:0]    payload,
    output logic                                  done,
    output logic [1:0]                            status,
    output logic [bmh_pkg::KEY_PORT_W-1:0]        min_key,
    output logic [bmh_pkg::PAYLOAD_PORT_W-1:0]    min_payload,
    output logic [bmh_pkg::COUNT_PORT_W-1:0]      count
);

    localparam int unsigned IDX_W   = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int unsigned CNT_W   = $clog2(HEAP_DEPTH + 1);
    localparam int unsigned CHILD_W = IDX_W + 2;
    localparam int unsigned ENT_W   = KEY_BITS + PAYLOAD_BITS;

    // One-hot sequencer states
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_UP_RD   = 7'b0000010,
        S_UP_CMP  = 7'b0000100,
        S_RM_RD   = 7'b0001000,
        S_RM_LOAD = 7'b0010000,
        S_DN_RD   = 7'b0100000,
        S_DN_CMP  = 7'b1000000
    } state_t;

    // ------------------------------------------------------------------
    // Heap memory: one write port, two registered read ports
    // ------------------------------------------------------------------
    logic [ENT_W-1:0] heap_mem [HEAP_DEPTH];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
    logic [ENT_W-1:0] rdata_a_reg;
    logic [ENT_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        rdata_a_reg <= heap_mem[raddr_a];
        rdata_b_reg <= heap_mem[raddr_b];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic                    done_reg, done_next;
    bmh_pkg::status_t        status_reg, status_next;
    logic [ENT_W-1:0]        cur_reg, cur_next;
    logic [KEY_BITS-1:0]     res_key_reg, res_key_next;
    logic [PAYLOAD_BITS-1:0] res_pay_reg, res_pay_next;

    // Derived addresses and compares
    logic [ENT_W-1:0]    new_entry;
    logic [IDX_W-1:0]    parent_idx;
    logic [CHILD_W-1:0]  lc_w;
    logic [CHILD_W-1:0]  rc_w;
    logic                lc_ok;
    logic                rc_ok;
    logic [KEY_BITS-1:0] cur_k;
    logic [KEY_BITS-1:0] a_k;
    logic [KEY_BITS-1:0] b_k;
    logic                take_l;
    logic                take_r;
    logic                heap_full;

    assign new_entry  = {KEY_BITS'(key), PAYLOAD_BITS'(payload)};
    assign parent_idx = (pos_reg - IDX_W'(1)) >> 1;
    assign lc_w       = CHILD_W'({pos_reg, 1'b1});
    assign rc_w       = lc_w + CHILD_W'(1);
    assign lc_ok      = lc_w < CHILD_W'(count_reg);
    assign rc_ok      = rc_w < CHILD_W'(count_reg);
    assign cur_k      = cur_reg[ENT_W-1:PAYLOAD_BITS];
    assign a_k        = rdata_a_reg[ENT_W-1:PAYLOAD_BITS];
    assign b_k        = rdata_b_reg[ENT_W-1:PAYLOAD_BITS];
    assign heap_full  = count_reg == CNT_W'(HEAP_DEPTH);

    // Left child wins ties; right only if strictly below the better so far
    always_comb
    begin
        take_l = lc_ok && (a_k < cur_k);
        take_r = 1'b0;
        if (rc_ok)
        begin
            if (take_l)
            begin
                take_r = b_k < a_k;
            end
            else
            begin
                take_r = b_k < cur_k;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        cur_next     = cur_reg;
        res_key_next = res_key_reg;
        res_pay_next = res_pay_reg;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg;
        mem_wdata    = cur_reg;
        raddr_a      = '0;
        raddr_b      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_key_next = '0;
                    res_pay_next = '0;
                    if (action == bmh_pkg::ACT_INSERT)
                    begin
                        if (heap_full)
                        begin
                            status_next = bmh_pkg::ST_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            cur_next   = new_entry;
                            pos_next   = IDX_W'(count_reg);
                            count_next = count_reg + CNT_W'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bmh_pkg::ST_EMPTY;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_RM_RD;
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    // reached the root: drop the entry here
                    mem_we      = 1'b1;
                    status_next = bmh_pkg::ST_INSERTED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    raddr_a    = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cur_k < a_k)
                begin
                    // pull the parent down into the hole
                    mem_wdata  = rdata_a_reg;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    status_next = bmh_pkg::ST_INSERTED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_RM_RD:
            begin
                // root and the last entry, count already decremented
                raddr_a    = '0;
                raddr_b    = IDX_W'(count_reg);
                state_next = S_RM_LOAD;
            end

            S_RM_LOAD:
            begin
                res_key_next = rdata_a_reg[ENT_W-1:PAYLOAD_BITS];
                res_pay_next = rdata_a_reg[PAYLOAD_BITS-1:0];
                cur_next     = rdata_b_reg;
                pos_next     = '0;
                if (count_reg == '0)
                begin
                    status_next = bmh_pkg::ST_REMOVED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end

            S_DN_RD:
            begin
                raddr_a    = lc_w[IDX_W-1:0];
                raddr_b    = rc_w[IDX_W-1:0];
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (take_r)
                begin
                    mem_wdata  = rdata_b_reg;
                    pos_next   = rc_w[IDX_W-1:0];
                    state_next = S_DN_RD;
                end
                else if (take_l)
                begin
                    mem_wdata  = rdata_a_reg;
                    pos_next   = lc_w[IDX_W-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    status_next = bmh_pkg::ST_REMOVED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            pos_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= bmh_pkg::ST_INSERTED;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        res_key_reg <= res_key_next;
        res_pay_reg <= res_pay_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign busy        = state_reg != S_IDLE;
    assign done        = done_reg;
    assign status      = status_reg;
    assign min_key     = bmh_pkg::KEY_PORT_W'(res_key_reg);
    assign min_payload = bmh_pkg::PAYLOAD_PORT_W'(res_pay_reg);
    assign count       = bmh_pkg::COUNT_PORT_W'(count_reg);

endmodule
